// File: rtl/core/polar_rect_converter_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polar/rectangular converter
// Each macro expands to one labeled concurrent assertion on clk, off in rst.
// ---------------------------------------------------------------------------
`ifndef POLAR_RECT_CONVERTER_UNIT_DEFINES_SVH
`define POLAR_RECT_CONVERTER_UNIT_DEFINES_SVH

// same-cycle implication
`define PRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/prc_pkg.sv
// ---------------------------------------------------------------------------
// prc_pkg
// Types, constants and the arctangent table of the polar/rectangular converter.
// ---------------------------------------------------------------------------
package prc_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int GUARD_BITS = 4;
  localparam int OPER_W     = 24;
  localparam int R1_W       = 25;
  localparam int R2_W       = 24;
  // datapath x/y width and Q32 angle width
  localparam int XW = 32;
  localparam int ZW = 36;

  localparam longint PI_Q32       = 64'sd13493037705;
  localparam longint HALF_PI_Q32  = 64'sd6746518852;
  localparam longint TWO_PI_Q32   = 64'sd26986075409;
  localparam longint UPPER_Q32    = PI_Q32 + HALF_PI_Q32;
  localparam longint LOWER_Q32    = PI_Q32 - HALF_PI_Q32;
  localparam longint INV_GAIN_Q32 = 64'sd2608131496;

  localparam longint R1_MIN = -64'sd8388608;
  localparam longint R1_MAX = 64'sd11863283;
  localparam longint R2_MIN = -64'sd8388608;
  localparam longint R2_MAX = 64'sd8388607;

  typedef enum logic {
    OP_RECT_TO_POLAR = 1'b0,
    OP_POLAR_TO_RECT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      operation;
    logic signed [OPER_W-1:0] first_operand;
    logic signed [OPER_W-1:0] second_operand;
  } in_t;

  typedef struct packed {
    logic signed [R1_W-1:0] first_result;
    logic signed [R2_W-1:0] second_result;
  } out_t;

  // atan(2^-idx) in Q32 radians, rounded to nearest
  function automatic logic [31:0] atan_q32(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd3373259426;
      5'd1:    v = 32'd1991351318;
      5'd2:    v = 32'd1052175346;
      5'd3:    v = 32'd534100635;
      5'd4:    v = 32'd268086748;
      5'd5:    v = 32'd134174063;
      5'd6:    v = 32'd67103403;
      5'd7:    v = 32'd33553749;
      5'd8:    v = 32'd16777131;
      5'd9:    v = 32'd8388597;
      5'd10:   v = 32'd4194303;
      5'd11:   v = 32'd2097152;
      5'd12:   v = 32'd1048576;
      5'd13:   v = 32'd524288;
      5'd14:   v = 32'd262144;
      5'd15:   v = 32'd131072;
      5'd16:   v = 32'd65536;
      5'd17:   v = 32'd32768;
      5'd18:   v = 32'd16384;
      5'd19:   v = 32'd8192;
      5'd20:   v = 32'd4096;
      5'd21:   v = 32'd2048;
      5'd22:   v = 32'd1024;
      5'd23:   v = 32'd512;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/polar_rect_converter_unit.sv
// ---------------------------------------------------------------------------
// polar_rect_converter_unit
// Pipelined CORDIC converter between rectangular and polar coordinates.
// ---------------------------------------------------------------------------
// Takes one request per cycle and returns one result per request, in order.
// Every request passes an entry register, the angle wrap stages, a quadrant
// setup register, the unrolled CORDIC stages (one iteration per stage), a
// gain register and the output register. For polar to rectangular the angle
// wrap removes one binary multiple of 2*pi per stage. When the output is
// not taken the whole pipeline holds; otherwise a new request is taken every
// cycle. Rectangular to polar gives magnitude (25 bits) and atan2 angle in
// radians; the angle is 0 when both inputs are 0. Polar to rectangular wraps
// the angle into [-pi, pi) first. Results saturate to the R1/R2 limits in
// prc_pkg.
`include "polar_rect_converter_unit_defines.svh"

module polar_rect_converter_unit #(
  parameter int CORDIC_STEPS  = prc_pkg::CORDIC_STEPS_DEF,
  parameter int FRACTION_BITS = prc_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output prc_pkg::out_t out_data
);

  localparam int XW    = prc_pkg::XW;
  localparam int ZW    = prc_pkg::ZW;
  localparam int RED_Q = (FRACTION_BITS >= 22) ? 0 : 22 - FRACTION_BITS;
  localparam int RS    = RED_Q + 1;
  localparam int TW    = 36 + RED_Q;
  localparam int ASH   = 32 - FRACTION_BITS;
  localparam int GSH   = 32 + prc_pkg::GUARD_BITS;
  localparam int PW    = XW + 34;
  localparam int N     = CORDIC_STEPS;

  localparam logic signed [TW:0]   PI_T    = (TW+1)'(prc_pkg::PI_Q32);
  localparam logic signed [TW:0]   OFF_T   = (TW+1)'(prc_pkg::TWO_PI_Q32 <<< RED_Q);
  localparam logic [TW-1:0]        MOD_T   = TW'(prc_pkg::TWO_PI_Q32);
  localparam logic signed [ZW-1:0] PI_Z    = ZW'(prc_pkg::PI_Q32);
  localparam logic signed [ZW-1:0] HALF_Z  = ZW'(prc_pkg::HALF_PI_Q32);
  localparam logic signed [ZW-1:0] TWO_PI_Z = ZW'(prc_pkg::TWO_PI_Q32);
  localparam logic signed [ZW-1:0] UPPER_Z = ZW'(prc_pkg::UPPER_Q32);
  localparam logic signed [ZW-1:0] LOWER_Z = ZW'(prc_pkg::LOWER_Q32);
  localparam logic signed [33:0]   INV_G   = 34'(prc_pkg::INV_GAIN_Q32);
  localparam logic signed [PW-1:0] RND_G   = PW'(64'sd1 <<< (GSH - 1));
  localparam logic signed [ZW:0]   RND_Z   = (ZW+1)'(64'sd1 <<< (ASH - 1));
  localparam logic signed [PW-1:0] R1_MIN_P = PW'(prc_pkg::R1_MIN);
  localparam logic signed [PW-1:0] R1_MAX_P = PW'(prc_pkg::R1_MAX);
  localparam logic signed [PW-1:0] R2_MIN_P = PW'(prc_pkg::R2_MIN);
  localparam logic signed [PW-1:0] R2_MAX_P = PW'(prc_pkg::R2_MAX);
  localparam logic signed [ZW:0]   R2_MIN_Z = (ZW+1)'(prc_pkg::R2_MIN);
  localparam logic signed [ZW:0]   R2_MAX_Z = (ZW+1)'(prc_pkg::R2_MAX);

  logic adv;

  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // -------------------------------------------------------------------------
  // Entry stage and angle wrap stages
  // -------------------------------------------------------------------------
  logic                 r_vld  [0:RS];
  prc_pkg::op_t         r_op   [0:RS];
  logic                 r_zero [0:RS];
  logic signed [XW-1:0] r_x    [0:RS];
  logic signed [XW-1:0] r_y    [0:RS];
  logic signed [ZW-1:0] r_z    [0:RS];
  logic [TW-1:0]        r_t    [0:RS];

  logic signed [XW-1:0] a_ext, b_ext, x_in, y_in;
  logic signed [ZW-1:0] z_in;
  logic signed [TW:0]   ang_in, t_in;
  logic                 zero_in;

  always_comb begin
    a_ext   = XW'(in_data.first_operand) <<< prc_pkg::GUARD_BITS;
    b_ext   = XW'(in_data.second_operand) <<< prc_pkg::GUARD_BITS;
    ang_in  = (TW+1)'(in_data.second_operand) <<< ASH;
    // offset by a multiple of 2*pi so the wrap works on a nonnegative value
    t_in    = ang_in + PI_T + OFF_T;
    x_in    = a_ext;
    y_in    = '0;
    z_in    = '0;
    zero_in = 1'b0;
    if (in_data.operation == prc_pkg::OP_RECT_TO_POLAR) begin
      zero_in = (in_data.first_operand == '0) && (in_data.second_operand == '0);
      y_in    = b_ext;
      // fold the left half plane onto the right, start the angle at +/- pi
      if (in_data.first_operand < 0) begin
        x_in = -a_ext;
        y_in = -b_ext;
        z_in = (in_data.second_operand >= 0) ? PI_Z : -PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld[0] <= 1'b0;
    end else if (adv) begin
      r_vld[0] <= in_valid;
    end
    if (adv) begin
      r_op[0]   <= in_data.operation;
      r_zero[0] <= zero_in;
      r_x[0]    <= x_in;
      r_y[0]    <= y_in;
      r_z[0]    <= z_in;
      r_t[0]    <= t_in[TW-1:0];
    end
  end

  for (genvar k = 1; k <= RS; k++) begin : g_wrap
    localparam int            J   = RS - k;
    localparam logic [TW-1:0] THR = TW'(prc_pkg::TWO_PI_Q32 <<< J);

    always_ff @(posedge clk) begin
      if (rst) begin
        r_vld[k] <= 1'b0;
      end else if (adv) begin
        r_vld[k] <= r_vld[k-1];
      end
      if (adv) begin
        r_op[k]   <= r_op[k-1];
        r_zero[k] <= r_zero[k-1];
        r_x[k]    <= r_x[k-1];
        r_y[k]    <= r_y[k-1];
        r_z[k]    <= r_z[k-1];
        r_t[k]    <= (r_t[k-1] >= THR) ? r_t[k-1] - THR : r_t[k-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Quadrant setup and CORDIC stages
  // -------------------------------------------------------------------------
  logic                 c_vld  [0:N];
  prc_pkg::op_t         c_op   [0:N];
  logic                 c_zero [0:N];
  logic signed [XW-1:0] c_x    [0:N];
  logic signed [XW-1:0] c_y    [0:N];
  logic signed [ZW-1:0] c_z    [0:N];

  logic signed [ZW-1:0] t_wr, z_set;
  logic signed [XW-1:0] x_set;

  always_comb begin
    // wrapped value is below 2*pi, so it fits as a positive angle word
    t_wr  = $signed(r_t[RS][ZW-1:0]);
    x_set = r_x[RS];
    z_set = r_z[RS];
    if (r_op[RS] == prc_pkg::OP_POLAR_TO_RECT) begin
      if (t_wr > UPPER_Z) begin
        z_set = t_wr - TWO_PI_Z;
        x_set = -r_x[RS];
      end else if (t_wr < LOWER_Z) begin
        z_set = t_wr;
        x_set = -r_x[RS];
      end else begin
        z_set = t_wr - PI_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else if (adv) begin
      c_vld[0] <= r_vld[RS];
    end
    if (adv) begin
      c_op[0]   <= r_op[RS];
      c_zero[0] <= r_zero[RS];
      c_x[0]    <= x_set;
      c_y[0]    <= r_y[RS];
      c_z[0]    <= z_set;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] AT = ZW'(prc_pkg::atan_q32(5'(i)));

    logic                 up;
    logic signed [XW-1:0] xs, ys;

    assign up = (c_op[i] == prc_pkg::OP_POLAR_TO_RECT) ? !c_z[i][ZW-1] : c_y[i][XW-1];
    assign xs = c_x[i] >>> i;
    assign ys = c_y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_vld[i+1] <= 1'b0;
      end else if (adv) begin
        c_vld[i+1] <= c_vld[i];
      end
      if (adv) begin
        c_op[i+1]   <= c_op[i];
        c_zero[i+1] <= c_zero[i];
        c_x[i+1]    <= up ? c_x[i] - ys : c_x[i] + ys;
        c_y[i+1]    <= up ? c_y[i] + xs : c_y[i] - xs;
        c_z[i+1]    <= up ? c_z[i] - AT : c_z[i] + AT;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Gain correction, rounding and saturation
  // -------------------------------------------------------------------------
  logic                 m_vld;
  prc_pkg::op_t         m_op;
  logic                 m_zero;
  logic signed [ZW-1:0] m_z;
  logic signed [PW-1:0] m_px, m_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= c_vld[N];
    end
    if (adv) begin
      m_op   <= c_op[N];
      m_zero <= c_zero[N];
      m_z    <= c_z[N];
      m_px   <= c_x[N] * INV_G;
      m_py   <= c_y[N] * INV_G;
    end
  end

  logic signed [PW-1:0] px_r, py_r, r1_w, r2_w;
  logic signed [ZW:0]   z_r, z_w;
  prc_pkg::out_t        out_next;

  always_comb begin
    px_r = m_px + RND_G;
    py_r = m_py + RND_G;
    r1_w = px_r >>> GSH;
    r2_w = py_r >>> GSH;
    z_r  = (ZW+1)'(m_z) + RND_Z;
    z_w  = z_r >>> ASH;

    if (r1_w < R1_MIN_P) begin
      out_next.first_result = R1_MIN_P[prc_pkg::R1_W-1:0];
    end else if (r1_w > R1_MAX_P) begin
      out_next.first_result = R1_MAX_P[prc_pkg::R1_W-1:0];
    end else begin
      out_next.first_result = r1_w[prc_pkg::R1_W-1:0];
    end

    if (m_op == prc_pkg::OP_POLAR_TO_RECT) begin
      if (r2_w < R2_MIN_P) begin
        out_next.second_result = R2_MIN_P[prc_pkg::R2_W-1:0];
      end else if (r2_w > R2_MAX_P) begin
        out_next.second_result = R2_MAX_P[prc_pkg::R2_W-1:0];
      end else begin
        out_next.second_result = r2_w[prc_pkg::R2_W-1:0];
      end
    end else begin
      if (z_w < R2_MIN_Z) begin
        out_next.second_result = R2_MIN_Z[prc_pkg::R2_W-1:0];
      end else if (z_w > R2_MAX_Z) begin
        out_next.second_result = R2_MAX_Z[prc_pkg::R2_W-1:0];
      end else begin
        out_next.second_result = z_w[prc_pkg::R2_W-1:0];
      end
    end

    // zero vector: report zero magnitude and zero angle
    if (m_zero) begin
      out_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= m_vld;
    end
    if (adv) begin
      out_data <= out_next;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `PRC_ASSERT_IMPL(a_wrap_range, r_vld[RS] && r_op[RS] == prc_pkg::OP_POLAR_TO_RECT, r_t[RS] < MOD_T, "angle wrap left a value of 2*pi or more")
  `PRC_ASSERT_IMPL(a_setup_range, c_vld[0] && c_op[0] == prc_pkg::OP_POLAR_TO_RECT, c_z[0] <= HALF_Z && c_z[0] >= -HALF_Z, "rotation start angle outside half pi")
  `PRC_ASSERT_IMPL(a_vec_right_half, c_vld[0] && c_op[0] == prc_pkg::OP_RECT_TO_POLAR, !c_x[0][XW-1], "vectoring start x is negative")
  `PRC_ASSERT_NEXT(a_out_load, m_vld && adv, out_valid, "finished request did not reach the output")

endmodule

// File: bench/tb_polar_rect_converter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_polar_rect_converter_unit
// Drives CORDIC conversion requests of both directions through the converter
// with random idle cycles and back-pressure, predicts every result in
// 64-bit fixed point and checks the results in order, field by field.
// ---------------------------------------------------------------------------
module tb_polar_rect_converter_unit;

  localparam int STEPS       = prc_pkg::CORDIC_STEPS_DEF;
  localparam int FRAC        = prc_pkg::FRACTION_BITS_DEF;
  localparam int OW          = prc_pkg::OPER_W;
  localparam int PI_Q16      = 205887;
  localparam int HALF_PI_Q16 = 102944;
  localparam int MAX_OPER    = 8388607;
  localparam int MIN_OPER    = -8388608;
  localparam int RANDOM_REQUESTS = 1100;

  class conversion_scoreboard;
    prc_pkg::out_t expected_results[$];
    int            requests_noted;
    int            errors;

    function longint round_down_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint remove_gain(longint v);
      return round_down_shift(v * prc_pkg::INV_GAIN_Q32, 32 + prc_pkg::GUARD_BITS);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function prc_pkg::out_t predict_conversion(prc_pkg::in_t req);
      longint        a, b, x, y, z, dx, dy, r1, r2, at;
      prc_pkg::out_t res;
      a = longint'(req.first_operand);
      b = longint'(req.second_operand);
      if (req.operation == prc_pkg::OP_RECT_TO_POLAR) begin
        if (a == 0 && b == 0) begin
          r1 = 0;
          r2 = 0;
        end else begin
          x = a <<< prc_pkg::GUARD_BITS;
          y = b <<< prc_pkg::GUARD_BITS;
          z = 0;
          // fold the left half-plane onto the right one
          if (x < 0) begin
            z = (y >= 0) ? prc_pkg::PI_Q32 : -prc_pkg::PI_Q32;
            x = -x;
            y = -y;
          end
          for (int i = 0; i < STEPS; i++) begin
            at = longint'(prc_pkg::atan_q32(5'(i)));
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
              x -= dx;
              y += dy;
              z -= at;
            end else begin
              x += dx;
              y -= dy;
              z += at;
            end
          end
          r1 = remove_gain(x);
          r2 = round_down_shift(z, 32 - FRAC);
        end
      end else begin
        // wrap into [-pi, pi), then into [-pi/2, pi/2] with a flipped start
        z = b <<< (32 - FRAC);
        z = (z + prc_pkg::PI_Q32) % prc_pkg::TWO_PI_Q32;
        if (z < 0) z += prc_pkg::TWO_PI_Q32;
        z -= prc_pkg::PI_Q32;
        x = a <<< prc_pkg::GUARD_BITS;
        y = 0;
        if (z > prc_pkg::HALF_PI_Q32) begin
          z -= prc_pkg::PI_Q32;
          x = -x;
        end else if (z < -prc_pkg::HALF_PI_Q32) begin
          z += prc_pkg::PI_Q32;
          x = -x;
        end
        for (int i = 0; i < STEPS; i++) begin
          at = longint'(prc_pkg::atan_q32(5'(i)));
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= at;
          end else begin
            x += dx;
            y -= dy;
            z += at;
          end
        end
        r1 = remove_gain(x);
        r2 = remove_gain(y);
      end
      r1 = clip(r1, prc_pkg::R1_MIN, prc_pkg::R1_MAX);
      r2 = clip(r2, prc_pkg::R2_MIN, prc_pkg::R2_MAX);
      res.first_result  = r1[prc_pkg::R1_W-1:0];
      res.second_result = r2[prc_pkg::R2_W-1:0];
      return res;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void note_request(prc_pkg::in_t req);
      expected_results.push_back(predict_conversion(req));
      requests_noted++;
    endfunction

    function void check_result(prc_pkg::out_t got);
      prc_pkg::out_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("result %0d/%0d with no request pending",
                       got.first_result, got.second_result));
        return;
      end
      want = expected_results.pop_front();
      if (got.first_result !== want.first_result)
        flag($sformatf("first_result expected %0d got %0d",
                       want.first_result, got.first_result));
      if (got.second_result !== want.second_result)
        flag($sformatf("second_result expected %0d got %0d",
                       want.second_result, got.second_result));
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  prc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  prc_pkg::out_t out_data;
  bit            calm = 1'b0;

  conversion_scoreboard sb = new();

  polar_rect_converter_unit #(
    .CORDIC_STEPS  (STEPS),
    .FRACTION_BITS (FRAC)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random stalls, plus one long hold once the pipeline is busy
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && sb.requests_noted >= 300) begin
        hold_done = 1'b1;
        hold_left = 150;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(prc_pkg::op_t op, int a, int b);
    prc_pkg::in_t req;
    req.operation      = op;
    req.first_operand  = OW'(a);
    req.second_operand = OW'(b);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic int pick_coordinate();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 16777215)) + MIN_OPER;
      1:       v = int'($urandom_range(0, 262144)) - 131072;
      2:       v = int'($urandom_range(0, 2097152)) - 1048576;
      default: v = ($urandom_range(0, 1) != 0) ? MAX_OPER - int'($urandom_range(0, 15))
                                               : MIN_OPER + int'($urandom_range(0, 15));
    endcase
    return v;
  endfunction

  function automatic int pick_angle();
    int pick;
    int edge_val;
    pick = int'($urandom_range(0, 99));
    if (pick < 70) return int'($urandom_range(0, 2 * PI_Q16)) - PI_Q16;
    if (pick < 85) begin
      edge_val = ($urandom_range(0, 1) != 0) ? PI_Q16 : HALF_PI_Q16;
      if ($urandom_range(0, 1) != 0) edge_val = -edge_val;
      return edge_val + int'($urandom_range(0, 8)) - 4;
    end
    return int'($urandom_range(0, 16777215)) + MIN_OPER;
  endfunction

  initial begin
    prc_pkg::op_t op;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // vectoring corners: origin, negative x axis, extremes
    send_request(prc_pkg::OP_RECT_TO_POLAR, 0, 0);
    send_request(prc_pkg::OP_RECT_TO_POLAR, -65536, 0);
    send_request(prc_pkg::OP_RECT_TO_POLAR, -65536, -1);
    send_request(prc_pkg::OP_RECT_TO_POLAR, 65536, 0);
    send_request(prc_pkg::OP_RECT_TO_POLAR, 0, 65536);
    send_request(prc_pkg::OP_RECT_TO_POLAR, 0, -65536);
    send_request(prc_pkg::OP_RECT_TO_POLAR, MAX_OPER, MAX_OPER);
    send_request(prc_pkg::OP_RECT_TO_POLAR, MIN_OPER, MIN_OPER);
    send_request(prc_pkg::OP_RECT_TO_POLAR, MIN_OPER, 0);
    send_request(prc_pkg::OP_RECT_TO_POLAR, MAX_OPER, MIN_OPER);
    // rotation corners: quadrant folding, wrapping, negative and huge magnitude
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, 0);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, PI_Q16);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, -PI_Q16);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, HALF_PI_Q16 + 1);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, -HALF_PI_Q16 - 1);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, MAX_OPER);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 65536, MIN_OPER);
    send_request(prc_pkg::OP_POLAR_TO_RECT, -65536, 51472);
    send_request(prc_pkg::OP_POLAR_TO_RECT, MAX_OPER, 51472);
    send_request(prc_pkg::OP_POLAR_TO_RECT, MIN_OPER, -51472);
    send_request(prc_pkg::OP_POLAR_TO_RECT, 0, 0);
    send_request(prc_pkg::OP_POLAR_TO_RECT, MAX_OPER, 0);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 500 && n < 700);
      if (n == 850) begin
        // drain the pipeline before going on
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
      end
      op = ($urandom_range(0, 1) != 0) ? prc_pkg::OP_POLAR_TO_RECT
                                       : prc_pkg::OP_RECT_TO_POLAR;
      if (op == prc_pkg::OP_RECT_TO_POLAR)
        send_request(op, pick_coordinate(), pick_coordinate());
      else
        send_request(op, pick_coordinate(), pick_angle());
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    sb.errors += sb.expected_results.size();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/prc_pkg.sv
rtl/core/polar_rect_converter_unit.sv
bench/tb_polar_rect_converter_unit.sv
